// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Sizes, error codes and the structs passed between the queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   // queue sizing
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   // action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // broadcast from the queue control to every cell
   typedef struct packed {
      logic                          do_insert;
      logic                          do_remove;
      logic signed [VALUE_WIDTH-1:0] new_value;
   } spq_ctrl_type;

   // what a cell hands to its right-hand neighbor
   typedef struct packed {
      logic                          occupied;
      logic                          greater;
      logic signed [VALUE_WIDTH-1:0] value;
   } spq_link_type;

endpackage

`default_nettype wire

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage slot of the sorted priority queue
// Holds one entry, compares it with the item being inserted and shifts
// right on insert or left on remove together with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic                          clock,
   input  wire spq_ctrl_type                  ctrl,
   input  wire logic                          occupied,
   input  wire spq_link_type                  left_link,
   input  wire logic signed [VALUE_WIDTH-1:0] right_value,
   output spq_link_type                       out_link
);

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;
   logic                          greater;

   // stored entry sorts after the new item (equal entries stay ahead)
   assign greater = occupied && (value_ff > ctrl.new_value);

   // insert: make room or take the new item; remove: pull from the right
   always_comb begin
      value_in = value_ff;
      if (ctrl.do_insert) begin
         if (greater || (!occupied && left_link.occupied)) begin
            value_in = left_link.greater ? left_link.value : ctrl.new_value;
         end
      end else if (ctrl.do_remove) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign out_link.occupied = occupied;
   assign out_link.greater  = greater;
   assign out_link.value    = value_ff;

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded min-first queue kept in ascending order
// A row of compare-and-shift cells holds the entries; every item inserts a
// value or removes the smallest one and reports the new head.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  request   req_action, req_value                   start & !busy
//  response  rsp_head_value, rsp_is_empty,           rsp_valid, one cycle
//            rsp_is_full, rsp_error_code
//
//  One item per cycle: all cells compare against the new value in parallel
//  and shift in the same clock, so the result appears the cycle after start.
//  busy stays low; the cell row never holds up a request.
//  Reset clears the entry count and the response strobe; cell contents are
//  left as they are and only slots below the count are ever read.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_action,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]      rsp_head_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic [1:0]                         rsp_error_code
);

   logic [COUNT_WIDTH-1:0]        count_ff;
   logic [COUNT_WIDTH-1:0]        count_in;
   logic                          valid_ff;
   logic signed [VALUE_WIDTH-1:0] head_ff;
   logic signed [VALUE_WIDTH-1:0] head_in;
   logic                          empty_ff;
   logic                          full_ff;
   logic [1:0]                    error_ff;
   logic [1:0]                    error_in;
   logic                          accept;
   logic                          is_empty;
   logic                          is_full;
   spq_ctrl_type                  ctrl;
   spq_link_type                  links [0:CAPACITY];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == COUNT_WIDTH'(CAPACITY));

   // decode the item into cell commands
   always_comb begin
      ctrl.do_insert = 1'b0;
      ctrl.do_remove = 1'b0;
      ctrl.new_value = req_value;
      count_in       = count_ff;
      error_in       = ERR_OK;
      head_in        = head_ff;
      if (accept) begin
         unique case (req_action)
            ACT_INSERT: begin
               if (is_full) begin
                  error_in = ERR_FULL;
               end else begin
                  ctrl.do_insert = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (is_empty) begin
                  error_in = ERR_EMPTY;
               end else begin
                  ctrl.do_remove = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            default: begin
               error_in = ERR_OK;
            end
         endcase
      end
      // head after the action
      priority if (count_in == '0) begin
         head_in = '1;
      end else if (ctrl.do_insert) begin
         head_in = (is_empty || (links[1].value > req_value)) ? req_value
                                                              : links[1].value;
      end else if (ctrl.do_remove) begin
         head_in = links[2].value;
      end else begin
         head_in = links[1].value;
      end
   end

   // left edge of the row: always occupied, never greater
   assign links[0].occupied = 1'b1;
   assign links[0].greater  = 1'b0;
   assign links[0].value    = req_value;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] right_value;

      if (i < CAPACITY - 1) begin : g_inner
         assign right_value = links[i+2].value;
      end else begin : g_last
         assign right_value = links[i+1].value;
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > COUNT_WIDTH'(i)),
         .left_link   (links[i]),
         .right_value (right_value),
         .out_link    (links[i+1])
      );
   end

   // count and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         head_ff  <= head_in;
         empty_ff <= (count_in == '0);
         full_ff  <= (count_in == COUNT_WIDTH'(CAPACITY));
         error_ff <= error_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_head_value = head_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_is_full    = full_ff;
   assign rsp_error_code = error_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(CAPACITY))
      else $error("entry count above capacity");

   a_empty_head : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_head_value == '1)
      else $error("empty queue without all-ones head");

   a_full_error : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_FULL) |-> rsp_is_full)
      else $error("full error on a queue that is not full");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("item without result");

   a_order : assert property (@(posedge clock) disable iff (reset)
      count_ff >= COUNT_WIDTH'(2) |-> links[1].value <= links[2].value)
      else $error("head entries out of order");

endmodule

`default_nettype wire

// File: test/sorted_priority_queue_test.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Drives insert and remove items with random gaps. A shadow copy of the
// ordered entry list predicts the head, the flags and the error code of every
// item, and each strobed response is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import spq_pkg::*;

// status reported after each item
typedef struct packed {
   logic signed [VALUE_WIDTH-1:0] head_value;
   logic                          is_empty;
   logic                          is_full;
   logic [1:0]                    error_code;
} queue_status_type;

// shadow of the ordered entry list plus the predicted status of each item
class sorted_queue_shadow;
   logic signed [VALUE_WIDTH-1:0] entries[CAPACITY];
   int                            count;
   queue_status_type              expected_status[$];
   int                            failures;

   function new();
      count    = 0;
      failures = 0;
   endfunction

   // update the shadow list for one accepted item, queue the predicted status
   function void apply_item(logic action, logic signed [VALUE_WIDTH-1:0] value);
      queue_status_type st;
      int               pos;
      st.error_code = ERR_OK;
      if (action == ACT_INSERT) begin
         if (count >= CAPACITY) begin
            st.error_code = ERR_FULL;
         end else begin
            // new value goes after all entries equal to it
            pos = 0;
            while (pos < count && !(entries[pos] > value)) pos++;
            for (int i = count; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = value;
            count++;
         end
      end else if (count == 0) begin
         st.error_code = ERR_EMPTY;
      end else begin
         for (int i = 0; i + 1 < count; i++) entries[i] = entries[i+1];
         count--;
      end
      st.head_value = (count == 0) ? '1 : entries[0];
      st.is_empty   = (count == 0);
      st.is_full    = (count >= CAPACITY);
      expected_status.push_back(st);
   endfunction

   // compare one strobed response with the oldest prediction
   function void check_status(logic signed [VALUE_WIDTH-1:0] head_value,
                              logic is_empty, logic is_full,
                              logic [1:0] error_code);
      queue_status_type exp_st;
      if (expected_status.size() == 0) begin
         $error("response with no item outstanding: head_value %0d", head_value);
         failures++;
         return;
      end
      exp_st = expected_status.pop_front();
      if (head_value !== exp_st.head_value) begin
         $error("head_value: expected %0d, got %0d", exp_st.head_value, head_value);
         failures++;
      end
      if (is_empty !== exp_st.is_empty) begin
         $error("is_empty: expected %0d, got %0d", exp_st.is_empty, is_empty);
         failures++;
      end
      if (is_full !== exp_st.is_full) begin
         $error("is_full: expected %0d, got %0d", exp_st.is_full, is_full);
         failures++;
      end
      if (error_code !== exp_st.error_code) begin
         $error("error_code: expected %0d, got %0d", exp_st.error_code, error_code);
         failures++;
      end
   endfunction
endclass

module sorted_priority_queue_test;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 930;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_action;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_valid;
   logic signed [VALUE_WIDTH-1:0] rsp_head_value;
   logic                          rsp_is_empty;
   logic                          rsp_is_full;
   logic [1:0]                    rsp_error_code;

   sorted_queue_shadow shadow;
   int                 stall_cycles;
   int                 items_sent;
   bit                 steady;

   sorted_priority_queue dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_head_value (rsp_head_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .rsp_error_code (rsp_error_code)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // monitor: note accepted items, check responses, count dead cycles
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && !busy) shadow.apply_item(req_action, req_value);
         if (rsp_valid) begin
            shadow.check_status(rsp_head_value, rsp_is_empty, rsp_is_full,
                                rsp_error_code);
         end
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // watchdog
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // present one item after an optional random gap, return at the next falling edge
   task automatic send_item(logic action, logic signed [VALUE_WIDTH-1:0] value);
      while (!steady && $urandom_range(99) < 27) begin
         start      = 1'b0;
         req_action = 1'($urandom);
         req_value  = $urandom;
         @(negedge clock);
      end
      start      = 1'b1;
      req_action = action;
      req_value  = value;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // mix of duplicates, extremes and full-range values
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: return $signed($urandom_range(8)) - 4;
         4: begin
            case ($urandom_range(3))
               0:       return VALUE_MAX;
               1:       return VALUE_MIN;
               2:       return '1;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int mode;
      int burst_len;
      int insert_pct;
      shadow     = new();
      items_sent = 0;
      steady     = 1'b0;
      start      = 1'b0;
      req_action = ACT_INSERT;
      req_value  = '0;
      reset      = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: remove while empty, stored -1 versus empty, extremes, ties
      send_item(ACT_REMOVE, $urandom);
      send_item(ACT_INSERT, '1);
      send_item(ACT_REMOVE, '0);
      send_item(ACT_INSERT, VALUE_MAX);
      send_item(ACT_INSERT, VALUE_MIN);
      send_item(ACT_INSERT, '0);
      send_item(ACT_INSERT, '1);
      send_item(ACT_INSERT, '1);
      send_item(ACT_INSERT, 1);
      // fill up, then insert while full
      repeat (10) send_item(ACT_INSERT, pick_value());
      send_item(ACT_INSERT, VALUE_MIN);
      send_item(ACT_REMOVE, $urandom);

      // random bursts that lean toward filling or draining the queue
      while (items_sent < RANDOM_ITEMS + 21) begin
         mode      = $urandom_range(2);
         burst_len = $urandom_range(40, 8);
         case (mode)
            0:       insert_pct = 85;
            1:       insert_pct = 15;
            default: insert_pct = 50;
         endcase
         repeat (burst_len) begin
            steady = (items_sent >= 300 && items_sent < 450);
            if ($urandom_range(99) < insert_pct) send_item(ACT_INSERT, pick_value());
            else send_item(ACT_REMOVE, $urandom);
         end
      end
      start = 1'b0;

      // drain outstanding responses, then settle
      while (shadow.expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (shadow.failures == 0 && shadow.expected_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/sorted_priority_queue_test.sv
